// ===== src/direct_line_rasterizer_unit_defines.svh =====
// Assertion macros used by the line rasterizer sequencer (drlu_seq).
`ifndef DIRECT_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define DIRECT_LINE_RASTERIZER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define DRLU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("drlu: assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define DRLU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("drlu: assertion failed");
`else
`define DRLU_ASSERT_IMP(lbl, ante, cons)
`define DRLU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/drlu_pkg.sv =====
// Types and constants of the line rasterizer.
package drlu_pkg;

  localparam int COORD_BITS = 10;
  localparam int SIZE_BITS  = 4;
  // numerator 2*m0*D + 2*dm*k + D stays below 2^(2*COORD_BITS+1)
  localparam int NUM_W      = 2 * COORD_BITS + 2;
  localparam int DEN_W      = COORD_BITS + 1;
  localparam int CNT_W      = $clog2(COORD_BITS);

  localparam int IN_FIELDS_W = 4 * COORD_BITS + SIZE_BITS;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 2 * COORD_BITS + SIZE_BITS;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                 kind;
    logic [SIZE_BITS-1:0] point_size;
    coord_t               end_y;
    coord_t               end_x;
    coord_t               start_y;
    coord_t               start_x;
  } line_item_t;

  typedef struct packed {
    logic                 last;
    logic [SIZE_BITS-1:0] pixel_size;
    coord_t               pixel_y;
    coord_t               pixel_x;
  } pixel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_WAIT,
    S_EMIT
  } seq_state_t;

endpackage

// ===== src/drlu_div.sv =====
// Restoring divider, one quotient bit per cycle.
module drlu_div
  import drlu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  output logic                  done,
  output logic [COORD_BITS-1:0] quo
);

  logic [NUM_W-1:0]      rem_r, rem_nxt;
  logic [NUM_W-1:0]      dsh_r, dsh_nxt;
  logic [COORD_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic                  ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = NUM_W'(den) << (COORD_BITS - 1);
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(COORD_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[COORD_BITS-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== src/drlu_seq.sv =====
// Line state and sequencer around the shared divider.
`include "direct_line_rasterizer_unit_defines.svh"

module drlu_seq
  import drlu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  line_item_t            item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output pixel_t                res,
  output logic                  div_start,
  output logic [NUM_W-1:0]      div_num,
  output logic [DEN_W-1:0]      div_den,
  input  logic                  div_done,
  input  logic [COORD_BITS-1:0] div_quo
);

  seq_state_t state_r, state_nxt;

  logic                  active_r, active_nxt;
  coord_t                ox_r, ox_nxt, oy_r, oy_nxt;
  coord_t                tx_r, tx_nxt, ty_r, ty_nxt;
  coord_t                pos_r, pos_nxt;
  logic                  ymaj_r, ymaj_nxt;
  logic [SIZE_BITS-1:0]  size_r, size_nxt;
  coord_t                dmaj_r, dmaj_nxt;       // |delta| on the major axis
  logic [COORD_BITS:0]   dmin_r, dmin_nxt;       // signed delta on the minor axis
  logic [NUM_W-1:0]      num_r, num_nxt;

  coord_t                adx, ady, m0, tgt, minor;
  logic                  in_ymaj, fin;
  logic [2*COORD_BITS:0] prod;

  assign adx     = (item.end_x > item.start_x) ? item.end_x - item.start_x
                                               : item.start_x - item.end_x;
  assign ady     = (item.end_y > item.start_y) ? item.end_y - item.start_y
                                               : item.start_y - item.end_y;
  assign in_ymaj = (ady > adx);

  assign m0    = ymaj_r ? ox_r : oy_r;
  assign tgt   = ymaj_r ? ty_r : tx_r;
  assign fin   = (pos_r == tgt);
  assign prod  = m0 * {dmaj_r, 1'b0};
  assign minor = (dmaj_r == '0) ? m0 : div_quo;

  assign div_num = num_r;
  assign div_den = {dmaj_r, 1'b0};

  always_comb begin
    state_nxt  = state_r;
    active_nxt = active_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    tx_nxt     = tx_r;
    ty_nxt     = ty_r;
    pos_nxt    = pos_r;
    ymaj_nxt   = ymaj_r;
    size_nxt   = size_r;
    dmaj_nxt   = dmaj_r;
    dmin_nxt   = dmin_r;
    num_nxt    = num_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (item.kind == KIND_START) begin
            ox_nxt    = item.start_x;
            oy_nxt    = item.start_y;
            tx_nxt    = item.end_x;
            ty_nxt    = item.end_y;
            size_nxt  = item.point_size;
            ymaj_nxt  = in_ymaj;
            pos_nxt   = in_ymaj ? item.start_y : item.start_x;
            dmaj_nxt  = in_ymaj ? ady : adx;
            dmin_nxt  = in_ymaj
                      ? {1'b0, item.end_x} - {1'b0, item.start_x}
                      : {1'b0, item.end_y} - {1'b0, item.start_y};
            state_nxt = S_MUL;
          end else if (active_r) begin
            // step one pixel toward the target; k grows by one
            if (tgt > pos_r) begin
              pos_nxt = pos_r + 1'b1;
            end else if (tgt < pos_r) begin
              pos_nxt = pos_r - 1'b1;
            end
            num_nxt   = num_r + NUM_W'($signed({dmin_r, 1'b0}));
            state_nxt = (dmaj_r == '0) ? S_EMIT : S_DIV;
          end
        end
      end
      S_MUL: begin
        // numerator at k = 0: 2*m0*D + D
        num_nxt   = NUM_W'(prod) + NUM_W'(dmaj_r);
        state_nxt = (dmaj_r == '0) ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          active_nxt = !fin;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.pixel_x    = ymaj_r ? minor : pos_r;
    res.pixel_y    = ymaj_r ? pos_r : minor;
    res.pixel_size = size_r;
    res.last       = fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      active_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      active_r <= active_nxt;
    end
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    tx_r   <= tx_nxt;
    ty_r   <= ty_nxt;
    pos_r  <= pos_nxt;
    ymaj_r <= ymaj_nxt;
    size_r <= size_nxt;
    dmaj_r <= dmaj_nxt;
    dmin_r <= dmin_nxt;
    num_r  <= num_nxt;
  end

  `DRLU_ASSERT_IMP(a_div_nonzero, div_start, dmaj_r != '0)
  `DRLU_ASSERT_NXT(a_emit_to_idle, (state_r == S_EMIT) && res_ready, state_r == S_IDLE)
  `DRLU_ASSERT_NXT(a_last_ends_line, res_valid && res_ready && fin, !active_r)
  `DRLU_ASSERT_IMP(a_wait_no_input, state_r != S_IDLE, !in_ready)

endmodule

// ===== src/direct_line_rasterizer_unit.sv =====
// Top level of the slope-intercept line rasterizer.
//
// Streams pixels of a line drawn with the direct slope-intercept method.
// An input item with in_tuser = 0 loads both endpoints and a point size and
// yields the first pixel; each item with in_tuser = 1 yields the next pixel
// along the major axis (x when |dy| <= |dx|, else y), and out_tlast marks the
// final endpoint. The minor coordinate is floor(start + delta*k/D + 1/2),
// computed exactly: a numerator register steps by 2*delta_minor per pixel and
// a restoring divider takes one quotient bit per cycle. Equal endpoints give
// a single pixel with out_tlast set; a step item with no line in progress is
// consumed with no result; a new start abandons any line in progress.
// Sequence: a start item passes through the numerator multiply, the divider
// launch, the divider's quotient bits, the done hand-off and the output
// write; a step item skips the multiply, and equal endpoints skip the
// divider. in_tready is high only while no item is in work; the output
// register lets the next item start while a pixel still waits on out_tready.
module direct_line_rasterizer_unit
  import drlu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [9:0] start_x, [19:10] start_y, [29:20] end_x, [39:30] end_y,
  // [43:40] point_size, [47:44] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] kind: 0 start a line, 1 next pixel
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [9:0] pixel_x, [19:10] pixel_y, [23:20] pixel_size
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  line_item_t            item;
  pixel_t                res;
  logic                  res_valid, res_ready;
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      div_num;
  logic [DEN_W-1:0]      div_den;
  logic [COORD_BITS-1:0] div_quo;

  logic   out_valid_r, out_valid_nxt;
  pixel_t out_pix_r, out_pix_nxt;

  // unpack the input item
  assign item.kind       = in_tuser;
  assign item.start_x    = in_tdata[COORD_BITS-1:0];
  assign item.start_y    = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign item.end_x      = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign item.end_y      = in_tdata[4*COORD_BITS-1:3*COORD_BITS];
  assign item.point_size = in_tdata[IN_FIELDS_W-1:4*COORD_BITS];

  drlu_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_done  (div_done),
    .div_quo   (div_quo)
  );

  drlu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // output register: refilled when empty or drained in the same cycle
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_pix_r <= out_pix_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pix_r.pixel_size, out_pix_r.pixel_y, out_pix_r.pixel_x};
  assign out_tlast  = out_pix_r.last;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the direct slope-intercept line rasterizer.
`timescale 1ns / 100ps

module tb_top;
  import drlu_pkg::*;

  // Watchdog: sized for the slowest correct run, the block's own work plus the
  // longest send gap and the longest output stall per item, some 600 items in all.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int          RANDOM_PIXELS = 500;
  localparam int          MAX_IDLE      = 19;
  localparam int          DRAIN_CYCLES  = 30;   // margin over the block's latency

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = KIND_START;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  direct_line_rasterizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Line tracker: our own copy of the rasterizer state, reset values.
  // ---------------------------------------------------------------------
  bit                   line_on   = 1'b0;
  coord_t               org_x     = '0;
  coord_t               org_y     = '0;
  coord_t               tgt_x     = '0;
  coord_t               tgt_y     = '0;
  coord_t               major_pos = '0;
  bit                   y_major   = 1'b0;
  logic [SIZE_BITS-1:0] size_held = 1;

  pixel_t pixel_q[$];          // pixels still owed by the block, oldest first

  int errors          = 0;
  int pixels_expected = 0;
  int pixels_checked  = 0;
  int lines_started   = 0;
  int steps_ignored   = 0;
  bit quiet           = 1'b0;  // no idling on either side while set

  function automatic int idle_cycles();
    return quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  // Exact round-half-up minor coordinate at major position pos:
  // floor((2*m0*D + 2*dm*k + D) / (2*D)).
  function automatic coord_t rounded_minor(coord_t pos);
    longint m0, m1, a0, a1, d, k, num;
    if (y_major) begin
      m0 = org_x; m1 = tgt_x; a0 = org_y; a1 = tgt_y;
    end else begin
      m0 = org_y; m1 = tgt_y; a0 = org_x; a1 = tgt_x;
    end
    d = a1 - a0;
    if (d < 0) d = -d;
    if (d == 0) return coord_t'(m0);
    k = longint'(pos) - a0;
    if (k < 0) k = -k;
    num = 2 * m0 * d + 2 * (m1 - m0) * k + d;
    if (num < 0) num = 0;
    return coord_t'(num / (2 * d));
  endfunction

  // Advance the tracked line by one accepted item and queue its pixel.
  task automatic predict_pixel(line_item_t it);
    pixel_t px;
    coord_t goal, minor;
    int     adx, ady;
    if (it.kind == KIND_START) begin
      org_x     = it.start_x;
      org_y     = it.start_y;
      tgt_x     = it.end_x;
      tgt_y     = it.end_y;
      size_held = it.point_size;
      adx = (tgt_x > org_x) ? int'(tgt_x - org_x) : int'(org_x - tgt_x);
      ady = (tgt_y > org_y) ? int'(tgt_y - org_y) : int'(org_y - tgt_y);
      y_major   = ady > adx;       // ties and flat lines run along x
      major_pos = y_major ? org_y : org_x;
      lines_started++;
    end else if (!line_on) begin
      steps_ignored++;             // step with nothing in progress
      return;
    end else begin
      goal = y_major ? tgt_y : tgt_x;
      if (goal > major_pos) major_pos = major_pos + 1'b1;
      else if (goal < major_pos) major_pos = major_pos - 1'b1;
    end
    goal  = y_major ? tgt_y : tgt_x;
    minor = rounded_minor(major_pos);
    px.pixel_x    = y_major ? minor : major_pos;
    px.pixel_y    = y_major ? major_pos : minor;
    px.pixel_size = size_held;
    px.last       = (major_pos == goal);
    line_on       = !px.last;
    pixel_q       = {pixel_q, px};
    pixels_expected++;
  endtask

  // ---------------------------------------------------------------------
  // Output side: random out_tready stalls plus the pixel checker. Values
  // are read right at the edge, before any register update of that edge.
  // ---------------------------------------------------------------------
  int rx_wait = 0;

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_pixel();
    pixel_t got, want;
    got = {out_tlast, out_tdata};
    if (pixel_q.size() == 0) begin
      errors++;
      $display("%0t ns: unexpected pixel, expected none, actual x=%0d y=%0d size=%0d last=%0b",
               $time, got.pixel_x, got.pixel_y, got.pixel_size, got.last);
      return;
    end
    want = pixel_q.pop_front();
    pixels_checked++;
    compare_field("pixel_x", want.pixel_x, got.pixel_x);
    compare_field("pixel_y", want.pixel_y, got.pixel_y);
    compare_field("pixel_size", want.pixel_size, got.pixel_size);
    compare_field("last", want.last, got.last);
  endtask

  always @(posedge clk) begin : rx_side
    int rx_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait    <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_pixel();
        rx_next = idle_cycles();   // stall drawn per pixel
      end else begin
        rx_next = (rx_wait == 0) ? 0 : rx_wait - 1;
      end
      rx_wait    <= rx_next;
      out_tready <= (rx_next == 0);
    end
  end

  // ---------------------------------------------------------------------
  // Input side. in_tvalid stays high after an accept so that a back-to-back
  // item does not lower and raise it in one step; release_input drops it.
  // ---------------------------------------------------------------------
  task automatic release_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic send_item(line_item_t it);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, it[IN_FIELDS_W-1:0]};
    do @(posedge clk); while (!in_tready);
    predict_pixel(it);
  endtask

  // Step items carry junk in the endpoint fields; the block must ignore it.
  function automatic line_item_t step_item();
    line_item_t it;
    it.kind       = KIND_STEP;
    it.start_x    = coord_t'($urandom);
    it.start_y    = coord_t'($urandom);
    it.end_x      = coord_t'($urandom);
    it.end_y      = coord_t'($urandom);
    it.point_size = SIZE_BITS'($urandom);
    return it;
  endfunction

  task automatic draw_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                           logic [SIZE_BITS-1:0] ps, int steps);
    line_item_t it;
    it.kind       = KIND_START;
    it.start_x    = sx;
    it.start_y    = sy;
    it.end_x      = ex;
    it.end_y      = ey;
    it.point_size = ps;
    send_item(it);
    repeat (steps) send_item(step_item());
  endtask

  // Hold the sender until every owed pixel has come out.
  task automatic wait_drained();
    release_input();
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > (1 << COORD_BITS) - 1) return '1;
    return coord_t'(v);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Steps straight out of reset: nothing is active, no pixel may appear.
  task automatic test_no_line();
    repeat (2) send_item(step_item());
  endtask

  // Equal endpoints: a single pixel with last set, further steps ignored.
  task automatic test_single_pixel();
    draw_line(0, 0, 0, 0, 1, 1);
    draw_line(1023, 1023, 1023, 1023, 15, 0);
  endtask

  // Horizontal line run backwards with point size zero, vertical at the edge.
  task automatic test_axis_lines();
    draw_line(5, 7, 1, 7, 0, 4);
    draw_line(1023, 1020, 1023, 1023, 8, 3);
  endtask

  // Full-range diagonals abandoned by a new start, then a steep line with a
  // falling major axis run past its end, plus one rounding-half case.
  task automatic test_diagonals();
    draw_line(0, 0, 1023, 1023, 15, 1);
    draw_line(1023, 0, 0, 1023, 1, 1);
    draw_line(10, 20, 12, 15, 7, 6);
    draw_line(0, 0, 4, 1, 3, 4);
  endtask

  // Mostly well-formed short lines with random content; some long random
  // lines abandoned early, some overrun with extra steps, some lone steps.
  task automatic test_random_lines();
    int     base, pick, len, steps, dx, dy, r;
    bit     paused;
    coord_t sx, sy, ex, ey;
    base   = pixels_expected;
    paused = 1'b0;
    while (pixels_expected - base < RANDOM_PIXELS) begin
      if (!paused && pixels_expected - base >= RANDOM_PIXELS / 2) begin
        wait_drained();            // sender holds off until the pipe is empty
        paused = 1'b1;
      end
      quiet = ($urandom_range(0, 4) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 10) begin
        repeat ($urandom_range(1, 3)) send_item(step_item());
      end else begin
        sx = coord_t'($urandom);
        sy = coord_t'($urandom);
        if (pick < 22) begin
          ex    = coord_t'($urandom);
          ey    = coord_t'($urandom);
          steps = $urandom_range(0, 6);
        end else begin
          ex  = clamp_coord(int'(sx) + int'($urandom_range(0, 48)) - 24);
          ey  = clamp_coord(int'(sy) + int'($urandom_range(0, 48)) - 24);
          dx  = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
          dy  = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
          len = (dx > dy) ? dx : dy;
          r   = $urandom_range(0, 9);
          if (r == 0) steps = $urandom_range(0, len);
          else if (r == 1) steps = len + $urandom_range(1, 2);
          else steps = len;
        end
        draw_line(sx, sy, ex, ey, SIZE_BITS'($urandom_range(0, 15)), steps);
      end
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_line();
    test_single_pixel();
    test_axis_lines();
    test_diagonals();
    wait_drained();
    test_random_lines();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_q.size() != 0) errors++;

    $display("Drew %0d lines: %0d pixels checked, %0d idle steps dropped, %0d errors.",
             lines_started, pixels_checked, steps_ignored, errors);
    $display("Stimulus: axis, diagonal, single-pixel and abandoned lines, random stalls.");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t ns: timeout, %0d pixels still owed", $time, pixel_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
